FILE: sv/pidarr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidarr_pkg
// Shared types and constants of the positional insert/delete array unit.
// ----------------------------------------------------------------------------
package pidarr_pkg;

  localparam int DEPTH  = 64;  // number of storage cells
  localparam int DATA_W = 32;  // element width
  localparam int POS_W  = 7;   // request position width
  localparam int CNT_W  = 7;   // element count width
  localparam int IDX_W  = 6;   // cell index width

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_VIEW   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t                 req_type;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [IDX_W-1:0]          elem_index;
    logic signed [DATA_W-1:0]  elem_value;
    logic [CNT_W-1:0]          elem_count;
    logic                      last;
  } rsp_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_UPDATE,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [POS_W-1:0]          pos;
    logic [IDX_W-1:0]          tail;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_VIEW
  } state_t;

endpackage

FILE: sv/pidarr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidarr_cell
// One storage cell of the array; shifts with its neighbors on command.
// ----------------------------------------------------------------------------
module pidarr_cell import pidarr_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0]  left_val,
  input  logic signed [DATA_W-1:0]  right_val,
  input  logic signed [DATA_W-1:0]  head_val,
  output logic signed [DATA_W-1:0]  val
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [DATA_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctrl.op)
      CELL_INSERT: begin
        if (MY_POS > ctrl.pos) begin
          val_next = left_val;
        end else if (MY_POS == ctrl.pos) begin
          val_next = ctrl.value;
        end
      end
      CELL_UPDATE: begin
        if (MY_POS == ctrl.pos) begin
          val_next = ctrl.value;
        end
      end
      CELL_DELETE: begin
        if (MY_POS >= ctrl.pos) begin
          val_next = right_val;
        end
      end
      CELL_ROTATE: begin
        // tail cell wraps the head around
        if (MY_IDX == ctrl.tail) begin
          val_next = head_val;
        end else begin
          val_next = right_val;
        end
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: sv/positional_insert_delete_array_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array_unit
// Ordered array of signed 32-bit elements with insert, update, delete, view.
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall / req) carries one request per
//   transfer: insert, update or delete at a position, or view of all elements
//   result channel (rsp_valid / rsp_stall / rsp) carries the results
//   insert, update, delete: one result, registered at the transfer; the
//   whole row of cells shifts on that same clock edge, so a new
//   request can follow every cycle while the result register is free
//   view: count results, the first through the view state and then the
//   result register, then one per cycle while the receiver does not stall;
//   an empty array gives a single result, registered at the transfer; the
//   head cell feeds the output and the row rotates by one for each result,
//   so only after the last element is loaded can the next request be taken
//   errors (full, bad position, empty) give one result and change nothing
//   reset clears the element count, the state and rsp_valid; cell contents
//   are not cleared, only positions below the count are ever read
//   while the receiver stalls, the result holds and the row is frozen;
//   req_stall rises while a view runs or once the result register is busy
// ----------------------------------------------------------------------------
module positional_insert_delete_array_unit import pidarr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp
);

  // control state
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [IDX_W-1:0]   view_idx;
  logic [IDX_W-1:0]   view_idx_next;

  // result register load
  logic               rsp_load;
  rsp_t               rsp_next;

  logic               out_free;
  logic               accept;
  logic [CNT_W-1:0]   count_m1;
  logic               view_last;
  cell_ctrl_t         ctrl;

  // row of cells
  logic signed [DATA_W-1:0] cell_val [DEPTH];

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign count_m1  = count - CNT_W'(1);
  assign view_last = (view_idx == count_m1[IDX_W-1:0]);

  // request decode, status and cell command
  always_comb begin
    state_next    = state;
    count_next    = count;
    view_idx_next = view_idx;
    rsp_load      = 1'b0;
    ctrl.op       = CELL_HOLD;
    ctrl.pos      = req.position;
    ctrl.tail     = count_m1[IDX_W-1:0];
    ctrl.value    = req.value;
    rsp_next.status     = STAT_OK;
    rsp_next.elem_index = '0;
    rsp_next.elem_value = '0;
    rsp_next.elem_count = count;
    rsp_next.last       = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          case (req.req_type)
            REQ_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                rsp_next.status = STAT_FULL;
              end else if (req.position > count) begin
                rsp_next.status = STAT_RANGE;
              end else begin
                ctrl.op    = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            REQ_UPDATE: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else if (req.position >= count) begin
                rsp_next.status = STAT_RANGE;
              end else begin
                ctrl.op = CELL_UPDATE;
              end
            end
            REQ_DELETE: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else if (req.position >= count) begin
                rsp_next.status = STAT_RANGE;
              end else begin
                ctrl.op    = CELL_DELETE;
                count_next = count_m1;
              end
            end
            REQ_VIEW: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else begin
                // stream starts next cycle from the head cell
                rsp_load      = 1'b0;
                state_next    = S_VIEW;
                view_idx_next = '0;
              end
            end
            default: begin
              rsp_load = 1'b0;
            end
          endcase
          rsp_next.elem_count = count_next;
        end
      end
      S_VIEW: begin
        // one element per cycle while the output is free; rotation restores order after count steps
        if (out_free) begin
          rsp_load            = 1'b1;
          rsp_next.elem_index = view_idx;
          rsp_next.elem_value = cell_val[0];
          rsp_next.last       = view_last;
          ctrl.op             = CELL_ROTATE;
          view_idx_next       = view_idx + IDX_W'(1);
          if (view_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      view_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      view_idx <= view_idx_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // chain of cells, each wired to its neighbors (itself at the ends) and to the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    pidarr_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

endmodule

FILE: sv/pidarr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidarr_checker
// Port-level checks of the positional insert/delete array unit.
// ----------------------------------------------------------------------------
module pidarr_checker import pidarr_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  req_valid,
  input logic  req_stall,
  input req_t  req,
  input logic  rsp_valid,
  input logic  rsp_stall,
  input rsp_t  rsp
);

  // an error result always ends its request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != STAT_OK) |-> rsp.last)
    else $error("error result without last");

  // count never exceeds capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.elem_count <= CNT_W'(DEPTH)))
    else $error("element count above capacity");

  // no new request while a view stream is unfinished
  a_view_block: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> req_stall)
    else $error("request taken during view stream");

  // a nonzero view index stays below the count
  a_view_idx: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STAT_OK && rsp.elem_index != '0)
      |-> (CNT_W'(rsp.elem_index) < rsp.elem_count))
    else $error("view index out of range");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind positional_insert_delete_array_unit pidarr_checker u_pidarr_checker (.*);
